// ----- sv/lpg_pkg.sv -----
// Shared types and constants for the line pixel generator.
package lpg_pkg;

  localparam int CoordBits = 12;
  localparam int ColorBits = 8;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] cur_x;
    logic signed [CoordBits-1:0] cur_y;
    logic [CoordBits:0]          error_acc;
    logic [CoordBits-1:0]        major_delta;
    logic [CoordBits-1:0]        minor_delta;
    logic [CoordBits-1:0]        steps_left;
    logic                        dir_x_neg;
    logic                        dir_y_neg;
    logic                        x_is_major;
    logic [ColorBits-1:0]        line_color;
    logic                        active;
  } line_state_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic [ColorBits-1:0]        color;
    logic                        last;
  } pixel_t;

endpackage

// ----- sv/lpg_step.sv -----
// Next-state and pixel logic for one start or step request.
module lpg_step (
  input  lpg_pkg::line_state_t                 state,
  input  logic                                 func,
  input  logic signed [lpg_pkg::CoordBits-1:0] x_start,
  input  logic signed [lpg_pkg::CoordBits-1:0] y_start,
  input  logic signed [lpg_pkg::CoordBits-1:0] x_end,
  input  logic signed [lpg_pkg::CoordBits-1:0] y_end,
  input  logic [lpg_pkg::ColorBits-1:0]        color,
  output lpg_pkg::line_state_t                 state_next,
  output logic                                 emit,
  output lpg_pkg::pixel_t                      pixel
);

  localparam int C = lpg_pkg::CoordBits;

  logic [C:0]   dx;
  logic [C:0]   dy;
  logic [C:0]   dx_mag;
  logic [C:0]   dy_mag;
  logic [C-1:0] adx;
  logic [C-1:0] ady;
  logic         x_maj;
  logic [C-1:0] major;
  logic [C-1:0] minor;

  logic [C:0]   err_sum;
  logic         minor_move;
  logic         move_x;
  logic         move_y;
  logic [C-1:0] steps_dec;

  // start: absolute deltas and major axis selection
  always_comb begin
    dx     = {x_end[C-1], x_end} - {x_start[C-1], x_start};
    dy     = {y_end[C-1], y_end} - {y_start[C-1], y_start};
    dx_mag = dx[C] ? ((C+1)'(0) - dx) : dx;
    dy_mag = dy[C] ? ((C+1)'(0) - dy) : dy;
    adx    = dx_mag[C-1:0];
    ady    = dy_mag[C-1:0];
    x_maj  = adx > ady;
    major  = x_maj ? adx : ady;
    minor  = x_maj ? ady : adx;
  end

  // step: error update and axis moves
  always_comb begin
    err_sum    = state.error_acc + {1'b0, state.minor_delta};
    minor_move = err_sum > {1'b0, state.major_delta};
    move_x     = state.x_is_major || minor_move;
    move_y     = !state.x_is_major || minor_move;
    steps_dec  = state.steps_left - C'(1);
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    if (func == lpg_pkg::FUNC_START) begin
      state_next.dir_x_neg   = dx[C];
      state_next.dir_y_neg   = dy[C];
      state_next.x_is_major  = x_maj;
      state_next.major_delta = major;
      state_next.minor_delta = minor;
      state_next.error_acc   = {2'b00, major[C-1:1]};
      state_next.steps_left  = major;
      state_next.cur_x       = x_start;
      state_next.cur_y       = y_start;
      state_next.line_color  = color;
      state_next.active      = major != '0;
      emit                   = 1'b1;
    end else if (state.active) begin
      if (move_x) begin
        state_next.cur_x = state.dir_x_neg ? state.cur_x - C'(1) : state.cur_x + C'(1);
      end
      if (move_y) begin
        state_next.cur_y = state.dir_y_neg ? state.cur_y - C'(1) : state.cur_y + C'(1);
      end
      state_next.error_acc  = minor_move ? err_sum - {1'b0, state.major_delta} : err_sum;
      state_next.steps_left = steps_dec;
      state_next.active     = steps_dec != '0;
      emit                  = 1'b1;
    end
  end

  assign pixel.x     = state_next.cur_x;
  assign pixel.y     = state_next.cur_y;
  assign pixel.color = state_next.line_color;
  assign pixel.last  = !state_next.active;

endmodule

// ----- sv/line_pixel_generator.sv -----
// Top level of the line pixel generator: line state, step logic and output buffer.
//
// Takes one request per cycle while in_ready is high: a start request emits the first
// pixel of a new line and each step request emits the next pixel until last_pixel marks
// the end point; a step with no line in progress emits nothing. The output has a result
// register plus a skid register: an emitted pixel goes to the skid register while the
// result register holds a pixel not yet taken, so in_ready stays high while one pixel
// waits and drops only when both hold a pixel not yet taken.
module line_pixel_generator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 func,
  input  logic signed [lpg_pkg::CoordBits-1:0] x_start,
  input  logic signed [lpg_pkg::CoordBits-1:0] y_start,
  input  logic signed [lpg_pkg::CoordBits-1:0] x_end,
  input  logic signed [lpg_pkg::CoordBits-1:0] y_end,
  input  logic [lpg_pkg::ColorBits-1:0]        color,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lpg_pkg::CoordBits-1:0] pixel_x,
  output logic signed [lpg_pkg::CoordBits-1:0] pixel_y,
  output logic [lpg_pkg::ColorBits-1:0]        pixel_color,
  output logic                                 last_pixel
);

  lpg_pkg::line_state_t state;
  lpg_pkg::line_state_t state_next;
  lpg_pkg::pixel_t      new_pixel;
  lpg_pkg::pixel_t      out_pixel;
  lpg_pkg::pixel_t      skid_pixel;
  logic                 emit;
  logic                 skid_valid;
  logic                 accept;
  logic                 push;
  logic                 take;
  logic                 out_free;

  lpg_step u_step (
    .state      (state),
    .func       (func),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .color      (color),
    .state_next (state_next),
    .emit       (emit),
    .pixel      (new_pixel)
  );

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;
  assign take     = out_valid && out_ready;
  assign out_free = !out_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_pixel <= skid_pixel;
      end else if (push) begin
        out_pixel <= new_pixel;
      end
    end else if (push) begin
      skid_pixel <= new_pixel;
    end
  end

  assign pixel_x     = out_pixel.x;
  assign pixel_y     = out_pixel.y;
  assign pixel_color = out_pixel.color;
  assign last_pixel  = out_pixel.last;

endmodule
